// ----- sv/pqss_pkg.sv -----
// Package for the priority queue scan-select block.
// Holds field widths, status and request codes, and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package pqss_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int ORDER_BITS_DEF   = 16;

    // Fixed port field widths.
    localparam int REQ_W     = 1;
    localparam int PAYLOAD_W = 32;
    localparam int PRIO_W    = 2;
    localparam int ORDER_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_INSERT = 1'b0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                latch_req;     // capture the accepted request
        logic                ins_write;     // write the request into the tail slot
        logic                cnt_inc;       // one more stored entry
        logic                cnt_dec;       // one entry removed
        logic                ptr_clear;     // start a scan at slot zero
        logic                ptr_from_best; // start shifting just above the chosen slot
        logic                rd_issue;      // read the slot at the pointer
        logic                scan_cmp;      // compare returned read data against the best
        logic                shift_wr;      // write returned read data one slot lower
        logic                set_status;    // record the result status
        logic [STATUS_W-1:0] status_code;
        logic                rem_flag;      // result carries the removed entry
        logic                load_out;      // move the result into the output register
    } pqss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_remove;  // latched request is a remove
        logic cnt_full;    // store holds DEPTH entries
        logic cnt_zero;    // store is empty
        logic rd_more;     // pointer is below the fill count
        logic rd_pending;  // a read is in flight
        logic scan_last;   // the last stored entry is being compared
    } pqss_sts_t;

endpackage

// ----- sv/pqss_ctrl.sv -----
// Controller state machine for the priority queue scan-select block.
// Drives datapath commands and the channel handshakes; depends on pqss_pkg.
`timescale 1ns / 1ps

module pqss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pqss_pkg::pqss_sts_t sts,
    output pqss_pkg::pqss_cmd_t cmd
);
    import pqss_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_SCAN       = 3'd2;
    localparam logic [2:0] S_SHIFT_INIT = 3'd3;
    localparam logic [2:0] S_SHIFT      = 3'd4;
    localparam logic [2:0] S_OUT        = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output register may be loaded when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == S_IDLE);

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_DONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!sts.req_remove) begin
                    cmd.set_status = 1'b1;
                    if (sts.cnt_full) begin
                        cmd.status_code = ST_FULL;
                    end else begin
                        cmd.ins_write = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                    end
                    state_next = S_OUT;
                end else if (sts.cnt_zero) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_EMPTY;
                    state_next      = S_OUT;
                end else begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_issue = sts.rd_more;
                cmd.scan_cmp = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_SHIFT_INIT;
                end
            end
            S_SHIFT_INIT: begin
                cmd.ptr_from_best = 1'b1;
                state_next        = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.rd_issue = sts.rd_more;
                cmd.shift_wr = 1'b1;
                if (!sts.rd_more && !sts.rd_pending) begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.rem_flag   = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid is set on load and cleared when the transaction completes.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pqss_ctrl: pending result dropped");

    // Every accepted request is followed by its decode step.
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("pqss_ctrl: accepted request not decoded");

    // A result is loaded only from the output state.
    a_load_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (state_reg == S_OUT) && out_free)
        else $error("pqss_ctrl: output loaded out of sequence");
`endif

endmodule

// ----- sv/pqss_dp.sv -----
// Datapath for the priority queue scan-select block: entry memory, fill count,
// scan pointer, best-entry tracking and the result register. Depends on pqss_pkg.
`timescale 1ns / 1ps

module pqss_dp #(
    parameter int DEPTH        = pqss_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = pqss_pkg::PAYLOAD_BITS_DEF,
    parameter int ORDER_BITS   = pqss_pkg::ORDER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [pqss_pkg::REQ_W-1:0]         s_req_type,
    input  logic [pqss_pkg::PAYLOAD_W-1:0]     s_payload,
    input  logic [pqss_pkg::PRIO_W-1:0]        s_priority_req,
    input  logic [pqss_pkg::ORDER_W-1:0]       s_order_tag,
    output logic [pqss_pkg::STATUS_W-1:0]      m_status,
    output logic [pqss_pkg::PAYLOAD_W-1:0]     m_out_payload,
    output logic [pqss_pkg::PRIO_W-1:0]        m_out_priority,
    output logic [pqss_pkg::ORDER_W-1:0]       m_out_order,
    output logic [pqss_pkg::FILL_W-1:0]        m_fill_count,
    output logic                               m_is_empty,
    input  pqss_pkg::pqss_cmd_t                cmd,
    output pqss_pkg::pqss_sts_t                sts
);
    import pqss_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = PAYLOAD_BITS + PRIO_W + ORDER_BITS;

    // Entry memory, packed as {payload, priority, order}.
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic [REQ_W-1:0]        req_type_reg;
    logic [PAYLOAD_BITS-1:0] req_pay_reg;
    logic [PRIO_W-1:0]       req_prio_reg;
    logic [ORDER_BITS-1:0]   req_ord_reg;

    logic [PAYLOAD_BITS-1:0] best_pay_reg;
    logic [PRIO_W-1:0]       best_prio_reg;
    logic [ORDER_BITS-1:0]   best_ord_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    logic [STATUS_W-1:0]     res_status_reg;
    logic                    res_rem_reg;

    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [PRIO_W-1:0]       rd_prio;
    logic [ORDER_BITS-1:0]   rd_ord;
    logic                    rd_better;

    logic [PAYLOAD_BITS+PAYLOAD_W-1:0] in_pay_ext;
    logic [ORDER_BITS+ORDER_W-1:0]     in_ord_ext;
    logic [PAYLOAD_BITS+PAYLOAD_W-1:0] out_pay_ext;
    logic [ORDER_BITS+ORDER_W-1:0]     out_ord_ext;
    logic [CNT_W+FILL_W-1:0]           fill_ext;

    // Input fields resized to the stored widths.
    assign in_pay_ext = {{PAYLOAD_BITS{1'b0}}, s_payload};
    assign in_ord_ext = {{ORDER_BITS{1'b0}}, s_order_tag};

    // Request capture at acceptance.
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_type_reg <= s_req_type;
            req_pay_reg  <= in_pay_ext[PAYLOAD_BITS-1:0];
            req_prio_reg <= s_priority_req;
            req_ord_reg  <= in_ord_ext[ORDER_BITS-1:0];
        end
    end

    // Write port: tail append on insert, one slot down while closing the gap.
    always_comb begin
        if (cmd.ins_write) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = {req_pay_reg, req_prio_reg, req_ord_reg};
        end else begin
            wr_en   = cmd.shift_wr && rd_vld_reg;
            wr_addr = rd_idx_reg - IDX_W'(1);
            wr_data = rd_data_reg;
        end
    end

    // Memory with one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    // Read tracking: which slot the returned data belongs to.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_issue;
        end
        if (cmd.rd_issue) begin
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        end
    end

    // Fill count and slot pointer.
    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.ptr_clear) begin
            ptr_next = '0;
        end else if (cmd.ptr_from_best) begin
            ptr_next = CNT_W'(best_idx_reg) + CNT_W'(1);
        end else if (cmd.rd_issue) begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Best-entry compare: higher priority wins, then smaller order, then lower slot.
    assign {rd_pay, rd_prio, rd_ord} = rd_data_reg;
    assign rd_better = (rd_idx_reg == '0) || (rd_prio > best_prio_reg) ||
                       ((rd_prio == best_prio_reg) && (rd_ord < best_ord_reg));

    always_ff @(posedge aclk) begin
        if (cmd.scan_cmp && rd_vld_reg && rd_better) begin
            best_pay_reg  <= rd_pay;
            best_prio_reg <= rd_prio;
            best_ord_reg  <= rd_ord;
            best_idx_reg  <= rd_idx_reg;
        end
    end

    // Result status for the current request.
    always_ff @(posedge aclk) begin
        if (cmd.set_status) begin
            res_status_reg <= cmd.status_code;
            res_rem_reg    <= cmd.rem_flag;
        end
    end

    // Output register.
    assign out_pay_ext = {{PAYLOAD_W{1'b0}}, best_pay_reg};
    assign out_ord_ext = {{ORDER_W{1'b0}}, best_ord_reg};
    assign fill_ext    = {{FILL_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status     <= res_status_reg;
            m_fill_count <= fill_ext[FILL_W-1:0];
            m_is_empty   <= (count_reg == '0);
            if (res_rem_reg) begin
                m_out_payload  <= out_pay_ext[PAYLOAD_W-1:0];
                m_out_priority <= best_prio_reg;
                m_out_order    <= out_ord_ext[ORDER_W-1:0];
            end else begin
                m_out_payload  <= '0;
                m_out_priority <= '0;
                m_out_order    <= '0;
            end
        end
    end

    // Status toward the controller.
    assign sts.req_remove = (req_type_reg == REQ_REMOVE);
    assign sts.cnt_full   = (count_reg == CNT_W'(DEPTH));
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.rd_more    = (ptr_reg < count_reg);
    assign sts.rd_pending = rd_vld_reg;
    assign sts.scan_last  = rd_vld_reg && (CNT_W'(rd_idx_reg) == (count_reg - CNT_W'(1)));

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("pqss_dp: fill count above capacity");

    // Appends only happen with a free slot.
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_write |-> (count_reg < CNT_W'(DEPTH)))
        else $error("pqss_dp: append into a full store");

    // Gap-closing writes stay inside the occupied region.
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_wr && rd_vld_reg) |->
            (rd_idx_reg != '0) && (CNT_W'(rd_idx_reg) < count_reg))
        else $error("pqss_dp: shift write out of range");

    // A removal only completes on a non-empty store.
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("pqss_dp: removal from an empty store");
`endif

endmodule

// ----- sv/priority_queue_scan_select.sv -----
// Top level of the priority queue scan-select block.
// Instantiates pqss_ctrl and pqss_dp; depends on pqss_pkg.
`timescale 1ns / 1ps

// Priority queue of up to DEPTH entries with first-come tie break. Each input
// transaction is an insert (appended at the tail, refused with status 1 when
// full) or a remove (the entry with the highest priority, then the smallest
// order number, then the lowest slot, is returned and later entries shift
// down; status 2 when empty). Every input transaction yields exactly one
// output transaction with the fill count and empty flag after the request.
// One request is processed at a time; all entries sit in a memory with a
// single registered read port and one write port, which sets the timing. An
// insert or a refused request goes from acceptance through the decode step
// to the output state. A remove does one read per stored entry for the scan,
// then one read per entry above the chosen slot to close the gap. A new
// request is accepted once the previous result is in the output register,
// even if it has not been taken yet. No clearing pass is needed after reset.
module priority_queue_scan_select #(
    parameter int DEPTH        = pqss_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = pqss_pkg::PAYLOAD_BITS_DEF,
    parameter int ORDER_BITS   = pqss_pkg::ORDER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pqss_pkg::REQ_W-1:0]     s_req_type,
    input  logic [pqss_pkg::PAYLOAD_W-1:0] s_payload,
    input  logic [pqss_pkg::PRIO_W-1:0]    s_priority_req,
    input  logic [pqss_pkg::ORDER_W-1:0]   s_order_tag,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pqss_pkg::STATUS_W-1:0]  m_status,
    output logic [pqss_pkg::PAYLOAD_W-1:0] m_out_payload,
    output logic [pqss_pkg::PRIO_W-1:0]    m_out_priority,
    output logic [pqss_pkg::ORDER_W-1:0]   m_out_order,
    output logic [pqss_pkg::FILL_W-1:0]    m_fill_count,
    output logic                           m_is_empty
);
    import pqss_pkg::*;

    pqss_cmd_t cmd;
    pqss_sts_t sts;

    // Sequencer for insert, scan, shift and result hand-off.
    pqss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Entry store, compare logic and result register.
    pqss_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .ORDER_BITS   (ORDER_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_payload      (s_payload),
        .s_priority_req (s_priority_req),
        .s_order_tag    (s_order_tag),
        .m_status       (m_status),
        .m_out_payload  (m_out_payload),
        .m_out_priority (m_out_priority),
        .m_out_order    (m_out_order),
        .m_fill_count   (m_fill_count),
        .m_is_empty     (m_is_empty),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
